[rtl/core/timestamped_frame_queue_unit_macros.svh]
// Assertion macros shared by the frame queue RTL.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef TIMESTAMPED_FRAME_QUEUE_UNIT_MACROS_SVH
`define TIMESTAMPED_FRAME_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define TFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame queue check failed");

`endif

[rtl/core/tfq_pkg.sv]
// Shared types and constants of the timestamped frame queue.
// Used by every module of the block; depends on nothing.
package tfq_pkg;

  localparam int TIME_W    = 31;
  localparam int RATE_W    = 20;
  localparam int FRAME_W   = 32;
  localparam int MS_W      = 10;
  localparam int DEN_MS_W  = RATE_W + MS_W;
  localparam int PROD_W    = FRAME_W + DEN_MS_W;
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int FIELD_W   = 4;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [MS_W-1:0]   MS_PER_S = MS_W'(1000);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SEEK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_RATE_NUM = 2'd0,
    REG_RATE_DEN = 2'd1,
    REG_DURATION = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic               slot_valid;
    logic [FIELD_W-1:0] slot;
    logic [TIME_W-1:0]  frame_time_ms;
    logic               show_frame;
    logic               overwrote_oldest;
    logic [FIELD_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_num;
    logic [RATE_W-1:0] rate_den;
    logic [TIME_W-1:0] duration;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_CONST,
    ST_MUL_FRAME,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_COMMIT,
    ST_WALK,
    ST_CHECK,
    ST_SEEK,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic mul_const;
    logic mul_frame;
    logic div_start;
    logic commit;
    logic read_head;
    logic pop;
    logic seek;
    logic publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic queued_nz;
    logic head_due;
    logic div_done;
    logic out_free;
  } ctl_sts_t;

endpackage

[rtl/core/tfq_regs.sv]
// Configuration registers of the frame queue behind an APB-style port.
// Depends on tfq_pkg for the register map and the configuration struct.
module tfq_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tfq_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tfq_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tfq_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output tfq_pkg::cfg_t                     cfg
);

  logic [tfq_pkg::RATE_W-1:0] num_r;
  logic [tfq_pkg::RATE_W-1:0] den_r;
  logic [tfq_pkg::TIME_W-1:0] dur_r;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= tfq_pkg::RATE_W'(25);
      den_r <= tfq_pkg::RATE_W'(1);
      dur_r <= '0;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        tfq_pkg::REG_RATE_NUM: num_r <= cfg_pwdata[tfq_pkg::RATE_W-1:0];
        tfq_pkg::REG_RATE_DEN: den_r <= cfg_pwdata[tfq_pkg::RATE_W-1:0];
        tfq_pkg::REG_DURATION: dur_r <= cfg_pwdata[tfq_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      tfq_pkg::REG_RATE_NUM: cfg_prdata = tfq_pkg::CFG_DATA_W'(num_r);
      tfq_pkg::REG_RATE_DEN: cfg_prdata = tfq_pkg::CFG_DATA_W'(den_r);
      tfq_pkg::REG_DURATION: cfg_prdata = tfq_pkg::CFG_DATA_W'(dur_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg.rate_num = num_r;
  assign cfg.rate_den = den_r;
  assign cfg.duration = dur_r;

endmodule

[rtl/core/tfq_div.sv]
// Radix-4 restoring divider that produces two quotient bits per cycle.
// Depends on tfq_pkg for the operand widths and the step count.
module tfq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tfq_pkg::PROD_W-1:0]  dividend,
  input  logic [tfq_pkg::RATE_W-1:0]  divisor,
  output logic [tfq_pkg::PROD_W-1:0]  quotient,
  output logic                        done
);

  logic [tfq_pkg::RATE_W-1:0] rem_r;
  logic [tfq_pkg::PROD_W-1:0] quo_r;
  logic [tfq_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [tfq_pkg::RATE_W:0]   trial_a;
  logic [tfq_pkg::RATE_W:0]   trial_b;
  logic [tfq_pkg::RATE_W-1:0] rem_a;
  logic [tfq_pkg::RATE_W-1:0] rem_b;
  logic                       bit_a;
  logic                       bit_b;

  always_comb begin
    trial_a = {rem_r, quo_r[tfq_pkg::PROD_W-1]};
    bit_a   = trial_a >= {1'b0, divisor};
    rem_a   = bit_a ? tfq_pkg::RATE_W'(trial_a - {1'b0, divisor})
                    : trial_a[tfq_pkg::RATE_W-1:0];
    trial_b = {rem_a, quo_r[tfq_pkg::PROD_W-2]};
    bit_b   = trial_b >= {1'b0, divisor};
    rem_b   = bit_b ? tfq_pkg::RATE_W'(trial_b - {1'b0, divisor})
                    : trial_b[tfq_pkg::RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + tfq_pkg::STEP_W'(1);
        if (cnt_r == tfq_pkg::STEP_W'(tfq_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_b;
      quo_r <= {quo_r[tfq_pkg::PROD_W-3:0], bit_a, bit_b};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[rtl/core/tfq_datapath.sv]
// Datapath of the frame queue: ring state, slot time memory, timestamp
// arithmetic and the result register. Depends on tfq_pkg and tfq_div.
`include "timestamped_frame_queue_unit_macros.svh"

module tfq_datapath #(
  parameter int SLOTS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfq_pkg::in_item_t   in_payload,
  input  tfq_pkg::cfg_t       cfg,
  input  tfq_pkg::ctl_cmd_t   cmd,
  output tfq_pkg::ctl_sts_t   sts,
  input  logic                out_stall,
  output logic                out_valid,
  output tfq_pkg::out_item_t  out_payload
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0]            head_r;
  logic [CNT_W-1:0]            count_r;
  logic [tfq_pkg::FRAME_W-1:0] frame_cnt_r;
  logic [tfq_pkg::TIME_W-1:0]  start_r;
  logic [tfq_pkg::FRAME_W-1:0] last_shown_r;

  logic [1:0]                  op_r;
  logic [tfq_pkg::TIME_W-1:0]  time_r;
  logic                        sel_valid_r;
  logic [IDX_W-1:0]            sel_slot_r;
  logic [tfq_pkg::TIME_W-1:0]  sel_time_r;
  logic                        over_r;

  logic [tfq_pkg::DEN_MS_W-1:0] den_ms_r;
  logic [tfq_pkg::PROD_W-1:0]   prod_r;

  logic [tfq_pkg::TIME_W-1:0]  slot_mem [SLOTS];
  logic [tfq_pkg::TIME_W-1:0]  rd_data_r;

  logic                        out_valid_r;
  tfq_pkg::out_item_t          out_payload_r;

  logic [tfq_pkg::RATE_W-1:0]  divisor;
  logic [tfq_pkg::PROD_W-1:0]  quotient;
  logic                        div_done;

  logic                        room;
  logic [SUM_W-1:0]            tail_sum;
  logic [IDX_W-1:0]            tail_slot;
  logic [IDX_W-1:0]            head_inc;
  logic [IDX_W-1:0]            wr_slot;
  logic [tfq_pkg::TIME_W:0]    time_sum;
  logic [tfq_pkg::TIME_W-1:0]  new_time;
  logic [tfq_pkg::TIME_W-1:0]  seek_time;
  logic                        show;

  assign divisor = (cfg.rate_num == '0) ? tfq_pkg::RATE_W'(1) : cfg.rate_num;

  tfq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    room      = count_r < CNT_W'(SLOTS);
    tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
    tail_slot = (tail_sum >= SUM_W'(SLOTS)) ? IDX_W'(tail_sum - SUM_W'(SLOTS))
                                            : IDX_W'(tail_sum);
    head_inc  = (head_r == IDX_W'(SLOTS - 1)) ? '0 : head_r + IDX_W'(1);
    wr_slot   = room ? tail_slot : head_r;
    time_sum  = {1'b0, start_r} + {1'b0, quotient[tfq_pkg::TIME_W-1:0]};
    new_time  = ((|quotient[tfq_pkg::PROD_W-1:tfq_pkg::TIME_W]) || time_sum[tfq_pkg::TIME_W])
                ? tfq_pkg::TIME_MAX : time_sum[tfq_pkg::TIME_W-1:0];
    seek_time = ((cfg.duration != '0) && (time_r > cfg.duration)) ? cfg.duration : time_r;
    show      = (op_r == tfq_pkg::OP_UPDATE) && sel_valid_r
                && ({1'b0, sel_time_r} != last_shown_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_mem[wr_slot] <= new_time;
    end
    if (cmd.read_head) begin
      rd_data_r <= slot_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_payload.operation;
      time_r      <= in_payload.time_ms;
      sel_valid_r <= 1'b0;
      sel_slot_r  <= '0;
      sel_time_r  <= '0;
      over_r      <= 1'b0;
    end else if (cmd.commit) begin
      sel_valid_r <= 1'b1;
      sel_slot_r  <= wr_slot;
      sel_time_r  <= new_time;
      over_r      <= !room;
    end else if (cmd.pop) begin
      sel_valid_r <= 1'b1;
      sel_slot_r  <= head_r;
      sel_time_r  <= rd_data_r;
    end
    if (cmd.mul_const) begin
      den_ms_r <= tfq_pkg::DEN_MS_W'(cfg.rate_den) * tfq_pkg::DEN_MS_W'(tfq_pkg::MS_PER_S);
    end
    if (cmd.mul_frame) begin
      prod_r <= tfq_pkg::PROD_W'(frame_cnt_r) * tfq_pkg::PROD_W'(den_ms_r);
    end
    if (cmd.publish) begin
      out_payload_r.slot_valid       <= sel_valid_r;
      out_payload_r.slot             <= tfq_pkg::FIELD_W'(sel_slot_r);
      out_payload_r.frame_time_ms    <= sel_time_r;
      out_payload_r.show_frame       <= show;
      out_payload_r.overwrote_oldest <= over_r;
      out_payload_r.occupancy        <= tfq_pkg::FIELD_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      count_r      <= '0;
      frame_cnt_r  <= '0;
      start_r      <= '0;
      last_shown_r <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        frame_cnt_r <= frame_cnt_r + tfq_pkg::FRAME_W'(1);
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          head_r <= head_inc;
        end
      end else if (cmd.pop) begin
        head_r  <= head_inc;
        count_r <= count_r - CNT_W'(1);
      end else if (cmd.seek) begin
        head_r       <= '0;
        count_r      <= '0;
        frame_cnt_r  <= '0;
        start_r      <= seek_time;
        last_shown_r <= '1;
      end
      if (cmd.publish && show) begin
        last_shown_r <= {1'b0, sel_time_r};
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.queued_nz = count_r != '0;
  assign sts.head_due  = rd_data_r <= time_r;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  `TFQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(SLOTS))
  `TFQ_ASSERT_SAME(a_head_bound, clk, rst_n, 1'b1, head_r <= IDX_W'(SLOTS - 1))
  `TFQ_ASSERT_SAME(a_show_needs_slot, clk, rst_n, out_valid_r && out_payload_r.show_frame, out_payload_r.slot_valid)
  `TFQ_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, cmd.pop, count_r == $past(count_r) - CNT_W'(1))

endmodule

[rtl/core/tfq_ctrl.sv]
// Controller state machine of the frame queue; sequences the datapath.
// Depends on tfq_pkg for the state, command and status types.
`include "timestamped_frame_queue_unit_macros.svh"

module tfq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_operation,
  output logic               in_stall,
  input  tfq_pkg::ctl_sts_t  sts,
  output tfq_pkg::ctl_cmd_t  cmd
);

  tfq_pkg::ctl_state_t state_r;
  tfq_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tfq_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            tfq_pkg::OP_ARRIVE: state_nxt = tfq_pkg::ST_MUL_CONST;
            tfq_pkg::OP_UPDATE: state_nxt = tfq_pkg::ST_WALK;
            tfq_pkg::OP_SEEK:   state_nxt = tfq_pkg::ST_SEEK;
            default:            state_nxt = tfq_pkg::ST_DONE;
          endcase
        end
      end
      tfq_pkg::ST_MUL_CONST: state_nxt = tfq_pkg::ST_MUL_FRAME;
      tfq_pkg::ST_MUL_FRAME: state_nxt = tfq_pkg::ST_DIV_GO;
      tfq_pkg::ST_DIV_GO:    state_nxt = tfq_pkg::ST_DIV_WAIT;
      tfq_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = tfq_pkg::ST_COMMIT;
        end
      end
      tfq_pkg::ST_COMMIT: state_nxt = tfq_pkg::ST_DONE;
      tfq_pkg::ST_WALK: begin
        state_nxt = sts.queued_nz ? tfq_pkg::ST_CHECK : tfq_pkg::ST_DONE;
      end
      tfq_pkg::ST_CHECK: begin
        state_nxt = sts.head_due ? tfq_pkg::ST_WALK : tfq_pkg::ST_DONE;
      end
      tfq_pkg::ST_SEEK: state_nxt = tfq_pkg::ST_DONE;
      tfq_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = tfq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = state_r != tfq_pkg::ST_IDLE;
    case (state_r)
      tfq_pkg::ST_IDLE:      cmd.capture   = in_valid;
      tfq_pkg::ST_MUL_CONST: cmd.mul_const = 1'b1;
      tfq_pkg::ST_MUL_FRAME: cmd.mul_frame = 1'b1;
      tfq_pkg::ST_DIV_GO:    cmd.div_start = 1'b1;
      tfq_pkg::ST_COMMIT:    cmd.commit    = 1'b1;
      tfq_pkg::ST_WALK:      cmd.read_head = sts.queued_nz;
      tfq_pkg::ST_CHECK:     cmd.pop       = sts.head_due;
      tfq_pkg::ST_SEEK:      cmd.seek      = 1'b1;
      tfq_pkg::ST_DONE:      cmd.publish   = sts.out_free;
      default: ;
    endcase
  end

  `TFQ_ASSERT_SAME(a_done_in_wait, clk, rst_n, sts.div_done, state_r == tfq_pkg::ST_DIV_WAIT)
  `TFQ_ASSERT_NEXT(a_publish_to_idle, clk, rst_n, cmd.publish, state_r == tfq_pkg::ST_IDLE)

endmodule

[rtl/core/timestamped_frame_queue_unit.sv]
// Frame arrival runs two multiplies, then the 31-step radix-4 divider that forms the
// frame offset, then a commit of the slot time before the result is published.
// A clock update reads and pops each due slot in turn and stops at an empty ring or
// at a slot not yet due; a seek resets the ring, and the unused code only publishes.
// One request is in flight at a time; the result register frees the input.
// Synchronous active-low reset clears ring control; the slot memory is not cleared.
module timestamped_frame_queue_unit #(
  parameter int SLOTS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tfq_pkg::in_item_t               in_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tfq_pkg::out_item_t              out_payload,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tfq_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tfq_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tfq_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  tfq_pkg::cfg_t     cfg;
  tfq_pkg::ctl_cmd_t cmd;
  tfq_pkg::ctl_sts_t sts;

  tfq_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tfq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_payload.operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  tfq_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule
